### rtl/assert_macros.svh
// Assertion macros shared by the RTL modules.
// No dependencies; include after the module port list.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/segint_pkg.sv
// Package for the segment intersection test: widths and orientation codes.
// No dependencies.
`timescale 1ns / 1ps

package segint_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int TOL_BITS       = 16;
    localparam int NUM_ORIENT     = 4;
    localparam int NUM_PROD       = 2 * NUM_ORIENT;

    typedef enum logic [1:0] {
        ORI_COLLINEAR = 2'd0,
        ORI_CW        = 2'd1,
        ORI_CCW       = 2'd2
    } t_orient;

endpackage

### rtl/segment_intersection_test.sv
// Segment intersection test: four-stage pipeline, one segment pair per cycle while i_stall is low.
// Depends on segint_pkg and assert_macros.svh.
//
// Input channel: i_valid / o_stall with the eight endpoint coordinates, each
// COORD_BITS wide, signed. A transaction completes when i_valid is high and
// o_stall is low. Output channel: o_valid / i_stall with o_segments_meet and
// o_proper_crossing; a transaction completes when o_valid is high and i_stall
// is low.
// Stages: coordinate differences and bounding box compares, the eight cross
// product multiplies, product subtract and tolerance compare, final combine
// into the output register.
// o_valid rises once the transaction has passed the four register stages;
// throughput is one transaction per cycle while i_stall is low; the multiplier stage
// holds eight COORD_BITS+1 square multipliers working in parallel.
// Each stage moves when the one after it is empty or moving, so bubbles
// collapse; o_stall rises only when all four stages hold data and i_stall is
// high. Nothing is lost or repeated while the receiver stalls.
// Tolerance is written through i_cfg_wr_en / i_cfg_wr_data; the user must write
// it only while the pipeline is empty, as the block itself does not enforce this.
// Synchronous active-low reset empties the pipeline and clears the tolerance to zero.
`timescale 1ns / 1ps

module segment_intersection_test
    import segint_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [TOL_BITS-1:0]          i_cfg_wr_data,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [COORD_BITS-1:0] i_a_start_x,
    input  logic signed [COORD_BITS-1:0] i_a_start_y,
    input  logic signed [COORD_BITS-1:0] i_a_end_x,
    input  logic signed [COORD_BITS-1:0] i_a_end_y,
    input  logic signed [COORD_BITS-1:0] i_b_start_x,
    input  logic signed [COORD_BITS-1:0] i_b_start_y,
    input  logic signed [COORD_BITS-1:0] i_b_end_x,
    input  logic signed [COORD_BITS-1:0] i_b_end_y,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_segments_meet,
    output logic                         o_proper_crossing
);

`include "assert_macros.svh"

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;
    localparam int VW = PW + 1;

    function automatic logic in_box(
        input logic signed [COORD_BITS-1:0] ax, input logic signed [COORD_BITS-1:0] ay,
        input logic signed [COORD_BITS-1:0] px, input logic signed [COORD_BITS-1:0] py,
        input logic signed [COORD_BITS-1:0] bx, input logic signed [COORD_BITS-1:0] by
    );
        in_box = ((px >= ax) || (px >= bx)) && ((px <= ax) || (px <= bx)) &&
                 ((py >= ay) || (py >= by)) && ((py <= ay) || (py <= by));
    endfunction

    logic [TOL_BITS-1:0] r_tol;

    logic en1, en2, en3, en4;
    logic r_vld1, r_vld2, r_vld3, r_vld4;

    logic signed [DW-1:0] n_ma [NUM_PROD];
    logic signed [DW-1:0] n_mb [NUM_PROD];
    logic signed [DW-1:0] r_ma [NUM_PROD];
    logic signed [DW-1:0] r_mb [NUM_PROD];
    logic [NUM_ORIENT-1:0] n_box, r_box1, r_box2, r_box3;

    logic signed [PW-1:0] r_prod [NUM_PROD];

    t_orient n_ori [NUM_ORIENT];
    t_orient r_ori [NUM_ORIENT];

    logic n_general, n_meet;
    logic r_meet, r_general;

    assign en4     = !r_vld4 || !i_stall;
    assign en3     = !r_vld3 || en4;
    assign en2     = !r_vld2 || en3;
    assign en1     = !r_vld1 || en2;
    assign o_stall = !en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol  <= '0;
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_tol <= i_cfg_wr_data;
            end
            if (en1) r_vld1 <= i_valid;
            if (en2) r_vld2 <= r_vld1;
            if (en3) r_vld3 <= r_vld2;
            if (en4) r_vld4 <= r_vld3;
        end
    end

    // Stage 1: operand differences; o = ma[2j]*mb[2j] - ma[2j+1]*mb[2j+1]
    always_comb begin
        n_ma[0] = DW'(i_a_end_y) - DW'(i_a_start_y);
        n_mb[0] = DW'(i_b_start_x) - DW'(i_a_end_x);
        n_ma[1] = DW'(i_a_end_x) - DW'(i_a_start_x);
        n_mb[1] = DW'(i_b_start_y) - DW'(i_a_end_y);
        n_ma[2] = DW'(i_a_end_y) - DW'(i_a_start_y);
        n_mb[2] = DW'(i_b_end_x) - DW'(i_a_end_x);
        n_ma[3] = DW'(i_a_end_x) - DW'(i_a_start_x);
        n_mb[3] = DW'(i_b_end_y) - DW'(i_a_end_y);
        n_ma[4] = DW'(i_b_end_y) - DW'(i_b_start_y);
        n_mb[4] = DW'(i_a_start_x) - DW'(i_b_end_x);
        n_ma[5] = DW'(i_b_end_x) - DW'(i_b_start_x);
        n_mb[5] = DW'(i_a_start_y) - DW'(i_b_end_y);
        n_ma[6] = DW'(i_b_end_y) - DW'(i_b_start_y);
        n_mb[6] = DW'(i_a_end_x) - DW'(i_b_end_x);
        n_ma[7] = DW'(i_b_end_x) - DW'(i_b_start_x);
        n_mb[7] = DW'(i_a_end_y) - DW'(i_b_end_y);

        n_box[0] = in_box(i_a_start_x, i_a_start_y, i_b_start_x, i_b_start_y,
                          i_a_end_x, i_a_end_y);
        n_box[1] = in_box(i_a_start_x, i_a_start_y, i_b_end_x, i_b_end_y,
                          i_a_end_x, i_a_end_y);
        n_box[2] = in_box(i_b_start_x, i_b_start_y, i_a_start_x, i_a_start_y,
                          i_b_end_x, i_b_end_y);
        n_box[3] = in_box(i_b_start_x, i_b_start_y, i_a_end_x, i_a_end_y,
                          i_b_end_x, i_b_end_y);
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_ma   <= n_ma;
            r_mb   <= n_mb;
            r_box1 <= n_box;
        end
    end

    // Stage 2: cross product terms
    always_ff @(posedge i_clk) begin
        if (en2) begin
            for (int k = 0; k < NUM_PROD; k++) begin
                r_prod[k] <= PW'(r_ma[k]) * PW'(r_mb[k]);
            end
            r_box2 <= r_box1;
        end
    end

    // Stage 3: orientation with tolerance band
    always_comb begin
        logic signed [VW-1:0] v;
        logic signed [VW-1:0] tol_pos;
        logic signed [VW-1:0] tol_neg;
        tol_pos = signed'({{(VW-TOL_BITS){1'b0}}, r_tol});
        tol_neg = -tol_pos;
        for (int j = 0; j < NUM_ORIENT; j++) begin
            v = VW'(r_prod[2*j]) - VW'(r_prod[2*j+1]);
            if (v > tol_pos) begin
                n_ori[j] = ORI_CW;
            end else if (v < tol_neg) begin
                n_ori[j] = ORI_CCW;
            end else begin
                n_ori[j] = ORI_COLLINEAR;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_ori  <= n_ori;
            r_box3 <= r_box2;
        end
    end

    // Stage 4: combine
    always_comb begin
        n_general = (r_ori[0] != r_ori[1]) && (r_ori[2] != r_ori[3]);
        n_meet    = n_general;
        for (int j = 0; j < NUM_ORIENT; j++) begin
            if (r_ori[j] == ORI_COLLINEAR && r_box3[j]) begin
                n_meet = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_meet    <= n_meet;
            r_general <= n_general;
        end
    end

    assign o_valid           = r_vld4;
    assign o_segments_meet   = r_meet;
    assign o_proper_crossing = r_general;

    `ASSERT_IMPL(a_crossing_meets, i_clk, i_rst_n, o_valid && o_proper_crossing, o_segments_meet)
    `ASSERT_IMPL(a_stall_only_full, i_clk, i_rst_n, o_stall, o_valid && i_stall && r_vld1)
    `ASSERT_NEXT(a_stage_moves, i_clk, i_rst_n, r_vld1 && en2, r_vld2)

endmodule

### sim/tb.sv
// Self-checking testbench for segment_intersection_test: drives segment pairs, predicts
// the meet and crossing flags internally, and checks every output transaction in order.
// Depends on segint_pkg and the segment_intersection_test RTL.
`timescale 1ns / 1ps

module tb
    import segint_pkg::*;
();

    localparam int COORD_W     = COORD_BITS_DEF;
    localparam int LIMIT       = 300000;
    localparam int HOLD_CYCLES = 200;

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef struct packed {
        t_coord a_start_x;
        t_coord a_start_y;
        t_coord a_end_x;
        t_coord a_end_y;
        t_coord b_start_x;
        t_coord b_start_y;
        t_coord b_end_x;
        t_coord b_end_y;
    } t_seg_pair;

    typedef struct packed {
        logic meet;
        logic crossing;
    } t_meet_flags;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_cfg_wr_en;
    logic [TOL_BITS-1:0] i_cfg_wr_data;
    logic                i_valid;
    logic                o_stall;
    t_coord              i_a_start_x, i_a_start_y, i_a_end_x, i_a_end_y;
    t_coord              i_b_start_x, i_b_start_y, i_b_end_x, i_b_end_y;
    logic                o_valid;
    logic                i_stall;
    logic                o_segments_meet;
    logic                o_proper_crossing;

    logic [TOL_BITS-1:0] tolerance;
    t_meet_flags         expected_flags[$];
    int                  errors;
    int                  cycle_count;
    int                  hold_left;
    int unsigned         send_idle_pct;
    int unsigned         stall_pct;

    segment_intersection_test #(.COORD_BITS(COORD_W)) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_a_start_x       (i_a_start_x),
        .i_a_start_y       (i_a_start_y),
        .i_a_end_x         (i_a_end_x),
        .i_a_end_y         (i_a_end_y),
        .i_b_start_x       (i_b_start_x),
        .i_b_start_y       (i_b_start_y),
        .i_b_end_x         (i_b_end_x),
        .i_b_end_y         (i_b_end_y),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_segments_meet   (o_segments_meet),
        .o_proper_crossing (o_proper_crossing)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic t_orient turn_of(longint px, longint py, longint qx, longint qy,
                                        longint rx, longint ry);
        longint prod_diff;
        longint mag;
        prod_diff = (qy - py) * (rx - qx) - (qx - px) * (ry - qy);
        mag = (prod_diff < 0) ? -prod_diff : prod_diff;
        if (mag <= longint'(tolerance))
            return ORI_COLLINEAR;
        return (prod_diff > 0) ? ORI_CW : ORI_CCW;
    endfunction

    function automatic bit in_span_box(longint ax, longint ay, longint px, longint py,
                                       longint bx, longint by);
        bit in_x;
        bit in_y;
        in_x = (px >= ((ax < bx) ? ax : bx)) && (px <= ((ax < bx) ? bx : ax));
        in_y = (py >= ((ay < by) ? ay : by)) && (py <= ((ay < by) ? by : ay));
        return in_x && in_y;
    endfunction

    function automatic t_meet_flags predict_meet(t_seg_pair p);
        longint      ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
        t_orient     o1, o2, o3, o4;
        t_meet_flags f;
        ax0 = p.a_start_x; ay0 = p.a_start_y; ax1 = p.a_end_x; ay1 = p.a_end_y;
        bx0 = p.b_start_x; by0 = p.b_start_y; bx1 = p.b_end_x; by1 = p.b_end_y;
        o1 = turn_of(ax0, ay0, ax1, ay1, bx0, by0);
        o2 = turn_of(ax0, ay0, ax1, ay1, bx1, by1);
        o3 = turn_of(bx0, by0, bx1, by1, ax0, ay0);
        o4 = turn_of(bx0, by0, bx1, by1, ax1, ay1);
        f.crossing = (o1 != o2) && (o3 != o4);
        f.meet = f.crossing
            || (o1 == ORI_COLLINEAR && in_span_box(ax0, ay0, bx0, by0, ax1, ay1))
            || (o2 == ORI_COLLINEAR && in_span_box(ax0, ay0, bx1, by1, ax1, ay1))
            || (o3 == ORI_COLLINEAR && in_span_box(bx0, by0, ax0, ay0, bx1, by1))
            || (o4 == ORI_COLLINEAR && in_span_box(bx0, by0, ax1, ay1, bx1, by1));
        return f;
    endfunction

    function automatic t_seg_pair pair_from(int c[8]);
        t_seg_pair p;
        p.a_start_x = t_coord'(c[0]);
        p.a_start_y = t_coord'(c[1]);
        p.a_end_x   = t_coord'(c[2]);
        p.a_end_y   = t_coord'(c[3]);
        p.b_start_x = t_coord'(c[4]);
        p.b_start_y = t_coord'(c[5]);
        p.b_end_x   = t_coord'(c[6]);
        p.b_end_y   = t_coord'(c[7]);
        return p;
    endfunction

    // Mix of full-range noise and shapes that hit the collinear and touching paths.
    function automatic t_seg_pair random_pair();
        int c[8];
        int corner[6] = '{-32768, -32767, -1, 0, 1, 32767};
        int sel, base_x, base_y, dx, dy, k;
        sel = $urandom_range(99);
        if (sel < 20) begin
            foreach (c[i]) c[i] = int'($urandom_range(65535)) - 32768;
        end else if (sel < 40) begin
            foreach (c[i]) c[i] = int'($urandom_range(16)) - 8;
        end else if (sel < 60) begin
            foreach (c[i]) c[i] = int'($urandom_range(2000)) - 1000;
            k = $urandom_range(1) * 2;
            if ($urandom_range(1)) begin
                c[4] = c[k];
                c[5] = c[k + 1];
            end else begin
                c[6] = c[k];
                c[7] = c[k + 1];
            end
        end else if (sel < 85) begin
            base_x = int'($urandom_range(40000)) - 20000;
            base_y = int'($urandom_range(40000)) - 20000;
            dx = int'($urandom_range(40)) - 20;
            dy = int'($urandom_range(40)) - 20;
            for (int i = 0; i < 4; i++) begin
                k = int'($urandom_range(20)) - 10;
                c[2 * i]     = base_x + k * dx;
                c[2 * i + 1] = base_y + k * dy;
            end
            if (sel >= 75) begin
                k = $urandom_range(7);
                c[k] = c[k] + int'($urandom_range(6)) - 3;
            end
        end else begin
            foreach (c[i]) c[i] = corner[$urandom_range(5)];
        end
        return pair_from(c);
    endfunction

    task automatic send_pair(input t_seg_pair p);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_a_start_x <= p.a_start_x;
        i_a_start_y <= p.a_start_y;
        i_a_end_x   <= p.a_end_x;
        i_a_end_y   <= p.a_end_y;
        i_b_start_x <= p.b_start_x;
        i_b_start_y <= p.b_start_y;
        i_b_end_x   <= p.b_end_x;
        i_b_end_y   <= p.b_end_y;
        @(posedge i_clk);
        while (o_stall !== 1'b0) @(posedge i_clk);
        expected_flags.insert(expected_flags.size(), predict_meet(p));
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_flags.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_tolerance(input logic [TOL_BITS-1:0] value);
        drain();
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        tolerance = value;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic test_directed_shapes();
        send_pair(pair_from('{-10, -10, 10, 10, -10, 10, 10, -10}));
        send_pair(pair_from('{-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768}));
        send_pair(pair_from('{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768}));
        send_pair(pair_from('{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767}));
        send_pair(pair_from('{0, 0, 10, 0, 0, 5, 10, 5}));
        send_pair(pair_from('{0, 0, 10, 10, 5, 5, 20, 20}));
        send_pair(pair_from('{0, 0, 5, 5, 6, 6, 9, 9}));
        send_pair(pair_from('{0, 0, 10, 0, 5, 0, 5, 8}));
        send_pair(pair_from('{0, 0, 4, 4, 4, 4, 8, 0}));
        send_pair(pair_from('{0, 0, 6, 6, 3, 3, 3, 3}));
        send_pair(pair_from('{0, 0, 6, 6, 3, 4, 3, 4}));
        send_pair(pair_from('{7, -7, 7, -7, 7, -7, 7, -7}));
        send_pair(pair_from('{1, 1, 1, 1, 2, 2, 2, 2}));
        send_pair(pair_from('{0, 0, 1, 1, 5, 0, 6, -3}));
        send_pair(pair_from('{-32768, -32768, 32767, -32768, 32767, 32767, -32768, 32767}));
        send_pair(pair_from('{32767, -32768, -32768, 32767, -32768, -32768, -32768, 32767}));
        send_pair(pair_from('{-1, -1, 0, 0, 0, -1, -1, 0}));
    endtask

    // Near-collinear endpoint with cross product magnitude 4 around the threshold.
    task automatic test_tolerance_threshold();
        logic [TOL_BITS-1:0] levels[4] = '{16'd3, 16'd4, 16'd65535, 16'd1};
        foreach (levels[i]) begin
            write_tolerance(levels[i]);
            send_pair(pair_from('{0, 0, 4, 4, 2, 3, 2, 10}));
            send_pair(pair_from('{0, 0, 100, 100, 50, 49, 80, -20}));
        end
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        stall_pct     = 0;
        @(negedge i_clk);
        i_valid   <= 1'b0;
        hold_left = HOLD_CYCLES;
        repeat (40) send_pair(random_pair());
    endtask

    task automatic test_random_phase(input int count, input int unsigned idle,
                                     input int unsigned stall,
                                     input logic [TOL_BITS-1:0] tol);
        write_tolerance(tol);
        send_idle_pct = idle;
        stall_pct     = stall;
        repeat (count) send_pair(random_pair());
    endtask

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left--;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin : check_result
        t_meet_flags want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (expected_flags.size() == 0) begin
                errors++;
                $display("%0t unexpected transaction: meet %b crossing %b",
                         $time, o_segments_meet, o_proper_crossing);
            end else begin
                want = expected_flags.pop_front();
                if (o_segments_meet !== want.meet) begin
                    errors++;
                    $display("%0t segments_meet: expected %b actual %b",
                             $time, want.meet, o_segments_meet);
                end
                if (o_proper_crossing !== want.crossing) begin
                    errors++;
                    $display("%0t proper_crossing: expected %b actual %b",
                             $time, want.crossing, o_proper_crossing);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        i_valid       = 1'b0;
        i_stall       = 1'b0;
        i_a_start_x   = '0;
        i_a_start_y   = '0;
        i_a_end_x     = '0;
        i_a_end_y     = '0;
        i_b_start_x   = '0;
        i_b_start_y   = '0;
        i_b_end_x     = '0;
        i_b_end_y     = '0;
        tolerance     = '0;
        errors        = 0;
        cycle_count   = 0;
        hold_left     = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_shapes();
        test_tolerance_threshold();
        test_random_phase(250, 0, 0, 16'd0);
        test_random_phase(250, 64, 0, 16'd65535);
        test_random_phase(250, 0, 64, TOL_BITS'($urandom_range(65535)));
        test_random_phase(250, 35, 35, TOL_BITS'($urandom_range(64)));
        test_backpressure();

        drain();
        repeat (8) @(posedge i_clk);
        if (errors == 0 && expected_flags.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
